/* hw/rtl/sso_pkg.sv */
// Shared widths, codes and result type of the spectrum sweep occupancy block.
package sso_pkg;

  localparam int CH_W   = 7;
  localparam int LVL_W  = 7;
  localparam int CNT_W  = 10;
  localparam int CMD_W  = 2;
  localparam int KIND_W = 2;
  localparam int MODE_W = 2;
  // Largest hit count times one hundred needs this many bits.
  localparam int PROD_W = 17;

  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int REGIX_W = 3;

  localparam int NUM_CHANNELS_DEF = 128;

  localparam logic [LVL_W-1:0] LVL_MAX = 7'd100;

  localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ABORT  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_LEVEL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ABORT = 2'd2;

  localparam logic [MODE_W-1:0] MODE_BOTH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_A    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_B    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FAST = 2'd3;

  localparam logic [REGIX_W-1:0] REG_MIN_CH    = 3'd0;
  localparam logic [REGIX_W-1:0] REG_MAX_CH    = 3'd1;
  localparam logic [REGIX_W-1:0] REG_SAMPLES   = 3'd2;
  localparam logic [REGIX_W-1:0] REG_MODE      = 3'd3;
  localparam logic [REGIX_W-1:0] REG_A_PRESENT = 3'd4;
  localparam logic [REGIX_W-1:0] REG_B_PRESENT = 3'd5;

  localparam logic [CH_W-1:0]   RST_MIN_CH  = 7'd0;
  localparam logic [CH_W-1:0]   RST_MAX_CH  = 7'd125;
  localparam logic [CNT_W-1:0]  RST_SAMPLES = 10'd32;
  localparam logic [MODE_W-1:0] RST_MODE    = MODE_BOTH;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CH_W-1:0]   channel;
    logic [LVL_W-1:0]  level_combined;
    logic [LVL_W-1:0]  level_a;
    logic [LVL_W-1:0]  level_b;
    logic [LVL_W-1:0]  peak_hold;
    logic              last;
  } result_t;

endpackage

/* hw/rtl/sso_if.sv */
// Handshake channels for detect commands in and occupancy results out.
interface sso_in_if;
  logic                       valid;
  logic                       ready;
  logic [sso_pkg::CMD_W-1:0]  command;
  logic                       detect_a;
  logic                       detect_b;

  modport source(output valid, command, detect_a, detect_b, input ready);
  modport sink(input valid, command, detect_a, detect_b, output ready);
endinterface

interface sso_out_if;
  logic                        valid;
  logic                        ready;
  logic [sso_pkg::KIND_W-1:0]  kind;
  logic [sso_pkg::CH_W-1:0]    channel;
  logic [sso_pkg::LVL_W-1:0]   level_combined;
  logic [sso_pkg::LVL_W-1:0]   level_a;
  logic [sso_pkg::LVL_W-1:0]   level_b;
  logic [sso_pkg::LVL_W-1:0]   peak_hold;
  logic                        last;

  modport source(output valid, kind, channel, level_combined, level_a, level_b, peak_hold,
                 last, input ready);
  modport sink(input valid, kind, channel, level_combined, level_a, level_b, peak_hold,
               last, output ready);
endinterface

/* hw/rtl/sso_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sso_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/sso_pct.sv */
// Bit-serial percentage unit: hits times one hundred over the window length, saturated.
module sso_pct (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [sso_pkg::CNT_W-1:0]  hits,
  input  logic [sso_pkg::CNT_W-1:0]  window,
  output logic                       done,
  output logic [sso_pkg::LVL_W-1:0]  level
);
  import sso_pkg::*;

  localparam int STEP_W = $clog2(PROD_W + 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(PROD_W - 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [PROD_W-1:0] quo;
  logic [PROD_W-1:0] hx;
  logic [PROD_W-1:0] prod;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              fits;

  // Times one hundred as 64 + 32 + 4.
  assign hx    = {{(PROD_W - CNT_W){1'b0}}, hits};
  assign prod  = (hx << 6) + (hx << 5) + (hx << 2);
  assign trial = {rem, quo[PROD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = (trial >= {1'b0, dvs});
  assign level = (quo > PROD_W'(LVL_MAX)) ? LVL_MAX : quo[LVL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= prod;
      rem <= '0;
      dvs <= window;
    end else if (busy) begin
      rem <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo <= {quo[PROD_W-2:0], fits};
    end
  end

endmodule

/* hw/rtl/spectrum_sweep_occupancy.sv */
// Channel sweep occupancy meter: counts detect hits per channel window and reports levels.
//
// Commands arrive on sample_in: start a sweep, one detect sample, or abort. Results leave
// on result_out, one beat each, with last set on the final beat caused by a command.
// Configuration is written through the APB port (six registers at byte offsets 4*i);
// pready is tied high and prdata returns the register value.
// A start or a sample that does not close a window gives no beat. A start on an empty
// range gives one completion beat, and an abort of a running sweep gives one abort beat.
// A sample that closes a window runs three percentages through one bit-serial divider,
// each as a load, the 17 quotient bits and the taking of the level. Each level beat then
// passes the peak-hold read, the update and the hand-over to the output register, and a
// completion beat adds a hand-over of its own.
// The block takes one command at a time; a result beat waits in an output register, and
// when the receiver stalls the sequencer waits with it before loading the next beat.
// Reset restores the register defaults, ends any sweep and marks every peak-hold entry
// as zero through one valid flag per channel, so no clearing pass is needed.
module spectrum_sweep_occupancy #(
  parameter int NUM_CHANNELS = sso_pkg::NUM_CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  sso_in_if.sink                      sample_in,
  sso_out_if.source                   result_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sso_pkg::ADDR_W-1:0]  paddr,
  input  logic [sso_pkg::DATA_W-1:0]  pwdata,
  output logic [sso_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import sso_pkg::*;

  localparam int PK_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int EXT_W = CH_W + 2;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DIV_GO   = 3'd1;
  localparam logic [2:0] S_DIV_WAIT = 3'd2;
  localparam logic [2:0] S_RD       = 3'd3;
  localparam logic [2:0] S_UPD      = 3'd4;
  localparam logic [2:0] S_EMIT     = 3'd5;

  localparam logic [1:0] DIV_A = 2'd0;
  localparam logic [1:0] DIV_B = 2'd1;
  localparam logic [1:0] DIV_E = 2'd2;

  localparam logic [1:0] NX_IDLE   = 2'd0;
  localparam logic [1:0] NX_ADV    = 2'd1;
  localparam logic [1:0] NX_SECOND = 2'd2;
  localparam logic [1:0] NX_DONE   = 2'd3;

  // Configuration registers.
  logic [CH_W-1:0]   chan_lo;
  logic [CH_W-1:0]   chan_hi;
  logic [CNT_W-1:0]  samples_per_channel;
  logic [MODE_W-1:0] radio_mode;
  logic              receiver_a_present;
  logic              receiver_b_present;

  // Sweep state.
  logic [2:0]        state;
  logic [CH_W-1:0]   current_channel;
  logic [CNT_W-1:0]  sample_index;
  logic [CNT_W-1:0]  hits_a;
  logic [CNT_W-1:0]  hits_b;
  logic [CNT_W-1:0]  hits_either;
  logic [LVL_W-1:0]  best_level;
  logic [CH_W-1:0]   best_channel;
  logic              sweeping;
  logic              fast_sweep;
  logic              use_a;
  logic              use_b;
  logic [NUM_CHANNELS-1:0] peak_vld;
  logic [1:0]        div_sel;
  logic [LVL_W-1:0]  lvl_a;
  logic [LVL_W-1:0]  lvl_b;
  logic [LVL_W-1:0]  lvl_c;
  logic              res_idx;
  result_t           pend;
  logic [1:0]        nx;
  logic              out_vld;
  result_t           out_r;

  logic              cfg_wr;
  logic [REGIX_W-1:0] cfg_ix;
  logic              in_acc;
  logic              out_load;
  logic [CNT_W-1:0]  wlen;
  logic [CH_W:0]     ch_plus1;
  logic [CH_W:0]     ch_next;
  logic              second;
  logic              sweep_end;
  logic              more;
  logic              pa;
  logic              pb;
  logic              fast_sel;
  logic              ua_pref;
  logic              ub_pref;
  logic              ua_sel;
  logic              ub_sel;
  logic              inc_a;
  logic              inc_b;
  logic              inc_e;
  logic [CNT_W:0]    idx_inc;
  logic              closes;
  logic [CH_W-1:0]   rch;
  logic [EXT_W-1:0]  rch_ext;
  logic              rch_stored;
  logic [PK_AW-1:0]  rch_addr;
  logic [LVL_W-1:0]  ram_rd;
  logic [LVL_W-1:0]  old_peak;
  logic [LVL_W-1:0]  new_peak;
  logic [LVL_W-1:0]  res_lc;
  logic [LVL_W-1:0]  res_la;
  logic [LVL_W-1:0]  res_lb;
  logic              ram_we;
  logic              pct_start;
  logic              pct_done;
  logic [CNT_W-1:0]  pct_hits;
  logic [LVL_W-1:0]  pct_level;
  logic              out_in_store;

  // ---------------------------------------------------------------- configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cfg_ix = paddr[ADDR_W-1:2];

  always_comb begin
    case (cfg_ix)
      REG_MIN_CH:    prdata = DATA_W'(chan_lo);
      REG_MAX_CH:    prdata = DATA_W'(chan_hi);
      REG_SAMPLES:   prdata = DATA_W'(samples_per_channel);
      REG_MODE:      prdata = DATA_W'(radio_mode);
      REG_A_PRESENT: prdata = DATA_W'(receiver_a_present);
      REG_B_PRESENT: prdata = DATA_W'(receiver_b_present);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_lo             <= RST_MIN_CH;
      chan_hi             <= RST_MAX_CH;
      samples_per_channel <= RST_SAMPLES;
      radio_mode          <= RST_MODE;
      receiver_a_present  <= 1'b1;
      receiver_b_present  <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_ix)
        REG_MIN_CH:    chan_lo             <= pwdata[CH_W-1:0];
        REG_MAX_CH:    chan_hi             <= pwdata[CH_W-1:0];
        REG_SAMPLES:   samples_per_channel <= pwdata[CNT_W-1:0];
        REG_MODE:      radio_mode          <= pwdata[MODE_W-1:0];
        REG_A_PRESENT: receiver_a_present  <= pwdata[0];
        REG_B_PRESENT: receiver_b_present  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- decode
  assign wlen      = (samples_per_channel == '0) ? CNT_W'(1) : samples_per_channel;
  assign ch_plus1  = {1'b0, current_channel} + 1'b1;
  assign ch_next   = {1'b0, current_channel} + (fast_sweep ? (CH_W+1)'(2) : (CH_W+1)'(1));
  assign second    = fast_sweep && (ch_plus1 <= {1'b0, chan_hi});
  assign sweep_end = ch_next > {1'b0, chan_hi};
  assign more      = fast_sweep && !res_idx && second;

  assign pa       = receiver_a_present;
  assign pb       = receiver_b_present;
  assign fast_sel = (radio_mode == MODE_FAST) && pa && pb;
  assign ua_pref  = pa && (radio_mode != MODE_B);
  assign ub_pref  = pb && (radio_mode != MODE_A);
  // With the mode excluding every present receiver, fall back to A, then B.
  assign ua_sel   = (ua_pref || ub_pref) ? ua_pref : pa;
  assign ub_sel   = (ua_pref || ub_pref) ? ub_pref : (!pa && pb);

  assign inc_a   = fast_sweep ? sample_in.detect_a : (use_a && sample_in.detect_a);
  assign inc_b   = fast_sweep ? (second && sample_in.detect_b) : (use_b && sample_in.detect_b);
  assign inc_e   = !fast_sweep && (inc_a || inc_b);
  assign idx_inc = {1'b0, sample_index} + 1'b1;
  assign closes  = idx_inc >= {1'b0, wlen};

  assign sample_in.ready = (state == S_IDLE);
  assign in_acc          = sample_in.valid && sample_in.ready;

  // ---------------------------------------------------------------- level result
  assign rch        = res_idx ? ch_plus1[CH_W-1:0] : current_channel;
  assign rch_ext    = {2'b00, rch};
  assign rch_stored = rch_ext < EXT_W'(NUM_CHANNELS);
  assign rch_addr   = rch_ext[PK_AW-1:0];
  assign old_peak   = (rch_stored && peak_vld[rch_addr]) ? ram_rd : '0;

  always_comb begin
    if (!fast_sweep) begin
      res_lc = lvl_c;
      res_la = lvl_a;
      res_lb = lvl_b;
    end else if (!res_idx) begin
      res_lc = lvl_a;
      res_la = lvl_a;
      res_lb = '0;
    end else begin
      res_lc = lvl_b;
      res_la = '0;
      res_lb = lvl_b;
    end
  end

  assign new_peak = (res_lc > old_peak) ? res_lc : old_peak;
  assign ram_we   = (state == S_UPD) && rch_stored;

  sso_ram #(
    .WIDTH (LVL_W),
    .DEPTH (NUM_CHANNELS)
  ) u_peak_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (rch_addr),
    .wr_data (new_peak),
    .rd_addr (rch_addr),
    .rd_data (ram_rd)
  );

  // ---------------------------------------------------------------- percentage unit
  assign pct_start = (state == S_DIV_GO);

  always_comb begin
    case (div_sel)
      DIV_A:   pct_hits = hits_a;
      DIV_B:   pct_hits = hits_b;
      default: pct_hits = hits_either;
    endcase
  end

  sso_pct u_pct (
    .clk    (clk),
    .rst    (rst),
    .start  (pct_start),
    .hits   (pct_hits),
    .window (wlen),
    .done   (pct_done),
    .level  (pct_level)
  );

  // ---------------------------------------------------------------- sequencer
  assign out_load = (state == S_EMIT) && (!out_vld || result_out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      current_channel <= '0;
      sample_index    <= '0;
      hits_a          <= '0;
      hits_b          <= '0;
      hits_either     <= '0;
      best_level      <= '0;
      best_channel    <= '0;
      sweeping        <= 1'b0;
      fast_sweep      <= 1'b0;
      use_a           <= 1'b0;
      use_b           <= 1'b0;
      peak_vld        <= '0;
      div_sel         <= DIV_A;
      res_idx         <= 1'b0;
      nx              <= NX_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (sample_in.command)
              CMD_START: begin
                if (pa || pb) begin
                  fast_sweep      <= fast_sel;
                  use_a           <= ua_sel;
                  use_b           <= ub_sel;
                  current_channel <= chan_lo;
                  best_channel    <= chan_lo;
                  best_level      <= '0;
                  sample_index    <= '0;
                  hits_a          <= '0;
                  hits_b          <= '0;
                  hits_either     <= '0;
                  if (chan_lo > chan_hi) begin
                    // Empty range: completes at once on the first channel.
                    sweeping <= 1'b0;
                    pend     <= '{kind: KIND_DONE, channel: chan_lo,
                                  level_combined: '0, level_a: '0, level_b: '0,
                                  peak_hold: '0, last: 1'b1};
                    nx       <= NX_IDLE;
                    state    <= S_EMIT;
                  end else begin
                    sweeping <= 1'b1;
                  end
                end
              end
              CMD_ABORT: begin
                if (sweeping) begin
                  sweeping <= 1'b0;
                  pend     <= '{kind: KIND_ABORT, channel: current_channel,
                                level_combined: '0, level_a: '0, level_b: '0,
                                peak_hold: '0, last: 1'b1};
                  nx       <= NX_IDLE;
                  state    <= S_EMIT;
                end
              end
              CMD_SAMPLE: begin
                if (sweeping) begin
                  hits_a       <= hits_a + CNT_W'(inc_a);
                  hits_b       <= hits_b + CNT_W'(inc_b);
                  hits_either  <= hits_either + CNT_W'(inc_e);
                  sample_index <= idx_inc[CNT_W-1:0];
                  if (closes) begin
                    div_sel <= DIV_A;
                    state   <= S_DIV_GO;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (pct_done) begin
            case (div_sel)
              DIV_A:   lvl_a <= pct_level;
              DIV_B:   lvl_b <= pct_level;
              default: lvl_c <= pct_level;
            endcase
            if (div_sel == DIV_E) begin
              sample_index <= '0;
              hits_a       <= '0;
              hits_b       <= '0;
              hits_either  <= '0;
              res_idx      <= 1'b0;
              state        <= S_RD;
            end else begin
              div_sel <= div_sel + 1'b1;
              state   <= S_DIV_GO;
            end
          end
        end
        S_RD: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (rch_stored) begin
            peak_vld[rch_addr] <= 1'b1;
          end
          if (res_lc > best_level) begin
            best_level   <= res_lc;
            best_channel <= rch;
          end
          pend <= '{kind: KIND_LEVEL, channel: rch, level_combined: res_lc,
                    level_a: res_la, level_b: res_lb,
                    peak_hold: rch_stored ? new_peak : '0,
                    last: !more && !sweep_end};
          if (more) begin
            nx <= NX_SECOND;
          end else if (sweep_end) begin
            nx <= NX_DONE;
          end else begin
            nx <= NX_ADV;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            case (nx)
              NX_SECOND: begin
                res_idx <= 1'b1;
                state   <= S_RD;
              end
              NX_DONE: begin
                sweeping <= 1'b0;
                pend     <= '{kind: KIND_DONE, channel: best_channel,
                              level_combined: best_level, level_a: '0, level_b: '0,
                              peak_hold: '0, last: 1'b1};
                nx       <= NX_IDLE;
              end
              NX_ADV: begin
                current_channel <= ch_next[CH_W-1:0];
                state           <= S_IDLE;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_load) begin
      out_vld <= 1'b1;
    end else if (result_out.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= pend;
    end
  end

  assign result_out.valid          = out_vld;
  assign result_out.kind           = out_r.kind;
  assign result_out.channel        = out_r.channel;
  assign result_out.level_combined = out_r.level_combined;
  assign result_out.level_a        = out_r.level_a;
  assign result_out.level_b        = out_r.level_b;
  assign result_out.peak_hold      = out_r.peak_hold;
  assign result_out.last           = out_r.last;

  assign out_in_store = {2'b00, out_r.channel} < EXT_W'(NUM_CHANNELS);

  // ---------------------------------------------------------------- assertions
  a_pct_done_waited: assert property (@(posedge clk) disable iff (rst)
    pct_done |-> state == S_DIV_WAIT)
    else $error("percentage unit finished outside its wait state");

  a_peak_not_below_level: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_r.kind == KIND_LEVEL && out_in_store
      |-> out_r.peak_hold >= out_r.level_combined)
    else $error("held peak below the level just reported");

  a_levels_saturate: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> out_r.level_combined <= LVL_MAX && out_r.level_a <= LVL_MAX
                && out_r.level_b <= LVL_MAX)
    else $error("occupancy level above one hundred percent");

  a_report_ends_sweep: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && pend.kind != KIND_LEVEL |-> !sweeping)
    else $error("completion or abort beat pending while the sweep still runs");

endmodule
